// ----- rtl/rmst_pkg.sv -----
// Shared constants, types and the node join function of the range minimum segment tree.
package rmst_pkg;

	localparam int LEVELS  = 10;
	localparam int LEAVES  = 1 << LEVELS;
	localparam int NODE_AW = LEVELS + 1;
	localparam int NODES   = 1 << NODE_AW;
	localparam int SIZE_W  = LEVELS + 1;
	localparam int SPAN_W  = NODE_AW + 1;
	localparam int POS_W   = LEVELS;
	localparam int KEY_W   = 16;
	localparam int TAG_W   = 16;

	typedef enum logic [0:0] {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [TAG_W-1:0] tag;
	} node_t;

	localparam node_t NODE_EMPTY = '{key: {KEY_W{1'b1}}, tag: {TAG_W{1'b0}}};

	typedef struct packed {
		logic clear;
		logic start_write;
		logic start_query;
		logic climb;
		logic issue_left;
		logic issue_right;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic wr_ok;
		logic at_root;
		logic more;
	} status_t;

	// The left operand comes first in position order; equal keys go right.
	function automatic node_t join_nodes(node_t a, node_t b);
		join_nodes = (a.key < b.key) ? a : b;
	endfunction

endpackage

// ----- rtl/rmst_req_if.sv -----
// Request channel: valid, ready and the write or query request fields.
interface rmst_req_if;
	logic                      valid;
	logic                      ready;
	logic [0:0]                opcode;
	logic [rmst_pkg::POS_W-1:0] position;
	logic [rmst_pkg::POS_W-1:0] right_end;
	logic [rmst_pkg::KEY_W-1:0] key_value;
	logic [rmst_pkg::TAG_W-1:0] tag_value;

	modport source (output valid, opcode, position, right_end, key_value, tag_value,
		input ready);
	modport sink (input valid, opcode, position, right_end, key_value, tag_value,
		output ready);
endinterface

// ----- rtl/rmst_rsp_if.sv -----
// Response channel: valid, ready and the minimum key with its tag.
interface rmst_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [rmst_pkg::KEY_W-1:0] min_key;
	logic [rmst_pkg::TAG_W-1:0] min_tag;

	modport source (output valid, min_key, min_tag, input ready);
	modport sink (input valid, min_key, min_tag, output ready);
endinterface

// ----- rtl/rmst_dpath.sv -----
// Datapath: node memory, climb and query registers, size register and result register.
module rmst_dpath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rmst_pkg::cmd_t              cmd,
	output rmst_pkg::status_t           status,
	input  logic [rmst_pkg::POS_W-1:0]  position,
	input  logic [rmst_pkg::POS_W-1:0]  right_end,
	input  logic [rmst_pkg::KEY_W-1:0]  key_value,
	input  logic [rmst_pkg::TAG_W-1:0]  tag_value,
	input  logic                        cfg_we,
	input  logic [rmst_pkg::SIZE_W-1:0] cfg_data,
	output logic [rmst_pkg::KEY_W-1:0]  min_key,
	output logic [rmst_pkg::TAG_W-1:0]  min_tag
);

	rmst_pkg::node_t node_mem [rmst_pkg::NODES];
	rmst_pkg::node_t rdata_q;
	rmst_pkg::node_t cur_q;
	rmst_pkg::node_t left_q;
	rmst_pkg::node_t right_q;
	rmst_pkg::node_t climb_node;
	rmst_pkg::node_t result;
	rmst_pkg::node_t wdata;

	logic [rmst_pkg::SIZE_W-1:0]  size_q;
	logic [rmst_pkg::NODE_AW-1:0] clr_cnt_q;
	logic [rmst_pkg::NODE_AW-1:0] idx_q;
	logic [rmst_pkg::SPAN_W-1:0]  lo_q;
	logic [rmst_pkg::SPAN_W-1:0]  hi_q;
	logic [rmst_pkg::KEY_W-1:0]   out_key_q;
	logic [rmst_pkg::TAG_W-1:0]   out_tag_q;
	logic                         jl_s1;
	logic                         jr_s1;

	logic [rmst_pkg::SIZE_W-1:0]  eff_size;
	logic [rmst_pkg::SIZE_W-1:0]  pos_ext;
	logic [rmst_pkg::SIZE_W-1:0]  rend_ext;
	logic [rmst_pkg::SIZE_W-1:0]  rend_clip;
	logic                         pos_ok;
	logic                         q_nonempty;
	logic [rmst_pkg::NODE_AW-1:0] leaf;
	logic [rmst_pkg::NODE_AW-1:0] parent;
	logic [rmst_pkg::SPAN_W-1:0]  hi_dec;
	logic [rmst_pkg::NODE_AW-1:0] waddr;
	logic [rmst_pkg::NODE_AW-1:0] raddr;
	logic                         we;

	always_comb begin
		eff_size   = (size_q > rmst_pkg::SIZE_W'(rmst_pkg::LEAVES)) ?
			rmst_pkg::SIZE_W'(rmst_pkg::LEAVES) : size_q;
		pos_ext    = rmst_pkg::SIZE_W'(position);
		rend_ext   = rmst_pkg::SIZE_W'(right_end);
		pos_ok     = pos_ext < eff_size;
		rend_clip  = (rend_ext > eff_size - rmst_pkg::SIZE_W'(1)) ?
			eff_size - rmst_pkg::SIZE_W'(1) : rend_ext;
		q_nonempty = pos_ok && (pos_ext <= rend_clip);
		leaf       = rmst_pkg::NODE_AW'(rmst_pkg::LEAVES) + rmst_pkg::NODE_AW'(position);
		parent     = idx_q >> 1;
		hi_dec     = hi_q - rmst_pkg::SPAN_W'(1);
		climb_node = idx_q[0] ? rmst_pkg::join_nodes(rdata_q, cur_q) :
			rmst_pkg::join_nodes(cur_q, rdata_q);
		result     = rmst_pkg::join_nodes(left_q, right_q);
	end

	always_comb begin
		we    = cmd.clear | cmd.start_write | cmd.climb;
		waddr = clr_cnt_q;
		wdata = rmst_pkg::NODE_EMPTY;
		if (cmd.start_write) begin
			waddr = leaf;
			wdata = '{key: key_value, tag: tag_value};
		end else if (cmd.climb) begin
			waddr = parent;
			wdata = climb_node;
		end
	end

	always_comb begin
		raddr = lo_q[rmst_pkg::NODE_AW-1:0];
		if (cmd.start_write) begin
			raddr = leaf ^ rmst_pkg::NODE_AW'(1);
		end else if (cmd.climb) begin
			raddr = parent ^ rmst_pkg::NODE_AW'(1);
		end else if (cmd.issue_right) begin
			raddr = hi_dec[rmst_pkg::NODE_AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			node_mem[waddr] <= wdata;
		end
		rdata_q <= node_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q    <= rmst_pkg::SIZE_W'(rmst_pkg::LEAVES);
			clr_cnt_q <= '0;
			jl_s1     <= 1'b0;
			jr_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				size_q <= cfg_data;
			end
			if (cmd.clear) begin
				clr_cnt_q <= clr_cnt_q + rmst_pkg::NODE_AW'(1);
			end
			jl_s1 <= cmd.issue_left & lo_q[0];
			jr_s1 <= cmd.issue_right & hi_q[0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_write) begin
			idx_q <= leaf;
			cur_q <= '{key: key_value, tag: tag_value};
		end else if (cmd.climb) begin
			idx_q <= parent;
			cur_q <= climb_node;
		end

		if (cmd.start_query) begin
			left_q  <= rmst_pkg::NODE_EMPTY;
			right_q <= rmst_pkg::NODE_EMPTY;
			if (q_nonempty) begin
				lo_q <= rmst_pkg::SPAN_W'(rmst_pkg::LEAVES) + rmst_pkg::SPAN_W'(position);
				hi_q <= rmst_pkg::SPAN_W'(rend_clip) + rmst_pkg::SPAN_W'(rmst_pkg::LEAVES)
					+ rmst_pkg::SPAN_W'(1);
			end else begin
				lo_q <= '0;
				hi_q <= '0;
			end
		end else begin
			if (jl_s1) begin
				left_q <= rmst_pkg::join_nodes(left_q, rdata_q);
			end
			if (jr_s1) begin
				right_q <= rmst_pkg::join_nodes(rdata_q, right_q);
			end
			if (cmd.issue_left) begin
				lo_q <= lo_q + rmst_pkg::SPAN_W'(lo_q[0]);
			end else if (cmd.issue_right) begin
				lo_q <= lo_q >> 1;
				hi_q <= hi_q >> 1;
			end
		end

		if (cmd.finish) begin
			out_key_q <= result.key;
			out_tag_q <= (result.key == rmst_pkg::NODE_EMPTY.key) ? '0 : result.tag;
		end
	end

	assign status.clr_last = (clr_cnt_q == rmst_pkg::NODE_AW'(rmst_pkg::NODES - 1));
	assign status.wr_ok    = pos_ok;
	assign status.at_root  = (parent == rmst_pkg::NODE_AW'(1));
	assign status.more     = lo_q < hi_q;

	assign min_key = out_key_q;
	assign min_tag = out_tag_q;

endmodule

// ----- rtl/rmst_ctrl.sv -----
// Controller: clearing sweep, write climb and query walk sequencing, result handshake.
module rmst_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	input  logic [0:0]              in_opcode,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  rmst_pkg::status_t       status,
	output rmst_pkg::cmd_t          cmd
);

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_CLIMB   = 6'b000100,
		S_Q_LEFT  = 6'b001000,
		S_Q_RIGHT = 6'b010000,
		S_DONE    = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (status.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_opcode == rmst_pkg::OP_QUERY) begin
						cmd.start_query = 1'b1;
						state_d         = S_Q_LEFT;
					end else if (status.wr_ok) begin
						cmd.start_write = 1'b1;
						state_d         = S_CLIMB;
					end
				end
			end
			S_CLIMB: begin
				cmd.climb = 1'b1;
				if (status.at_root) begin
					state_d = S_IDLE;
				end
			end
			S_Q_LEFT: begin
				if (status.more) begin
					cmd.issue_left = 1'b1;
					state_d        = S_Q_RIGHT;
				end else begin
					state_d = S_DONE;
				end
			end
			S_Q_RIGHT: begin
				cmd.issue_right = 1'b1;
				state_d         = S_Q_LEFT;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/range_min_argmin_segment_tree_unit.sv -----
// Top level of the range minimum segment tree with rightmost-position tag.
//
//   channel  direction  carries
//   req      in         opcode, position, right_end, key_value, tag_value
//   rsp      out        min_key, min_tag (one per query request)
//   cfg      in         size_in_use, write enable only
//
// After reset the node memory is swept to the empty node; no request is
// taken until the sweep is done, while size writes are taken at any time.
// A write request does the leaf write, then one step per tree level, each
// reading the sibling and writing the parent. A query walks at most 11 tree levels,
// with up to two reads per level on the single read port. A waiting
// result holds in its output register while the next request is accepted and worked on.
module range_min_argmin_segment_tree_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	rmst_req_if.sink                    req,
	rmst_rsp_if.source                  rsp,
	input  logic                        cfg_we,
	input  logic [rmst_pkg::SIZE_W-1:0] cfg_data
);

	rmst_pkg::cmd_t    cmd;
	rmst_pkg::status_t status;

	rmst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_opcode (req.opcode),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd)
	);

	rmst_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.position  (req.position),
		.right_end (req.right_end),
		.key_value (req.key_value),
		.tag_value (req.tag_value),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.min_key   (rsp.min_key),
		.min_tag   (rsp.min_tag)
	);

	// An empty result never carries a tag.
	a_empty_tag: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.min_key == rmst_pkg::NODE_EMPTY.key) |-> (rsp.min_tag == '0))
		else $error("empty result carries a nonzero tag");

	// A query request always occupies the unit for at least the following cycle.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.opcode == rmst_pkg::OP_QUERY) |=> !req.ready)
		else $error("query request accepted without starting a walk");

	// Results only appear from the finishing step, which is never in the idle state.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(!req.ready))
		else $error("result raised without a finished query");

endmodule

// ----- tb/sv/range_min_argmin_segment_tree_unit_tb.sv -----
// Self-checking testbench for the range minimum segment tree with rightmost-position tag.
module range_min_argmin_segment_tree_unit_tb;

	typedef struct {
		rmst_pkg::op_t              op;
		logic [rmst_pkg::POS_W-1:0] position;
		logic [rmst_pkg::POS_W-1:0] right_end;
		logic [rmst_pkg::KEY_W-1:0] key;
		logic [rmst_pkg::TAG_W-1:0] tag;
		int unsigned                lead_gap;
	} seg_req_t;

	logic                        clk = 1'b0;
	logic                        arst_n;
	logic                        cfg_we;
	logic [rmst_pkg::SIZE_W-1:0] cfg_data;

	rmst_req_if req_ch();
	rmst_rsp_if rsp_ch();

	range_min_argmin_segment_tree_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rmst_pkg::node_t             leaf_store [rmst_pkg::LEAVES];
	logic [rmst_pkg::SIZE_W-1:0] size_setting;
	rmst_pkg::node_t             expected_mins [$];
	seg_req_t                    pending_reqs [$];

	int unsigned queued_total;
	int unsigned requests_accepted;
	int unsigned results_seen;
	int unsigned queries_queued;
	int unsigned size_writes;
	int unsigned mismatches;
	bit          send_calm;

	function automatic int unsigned pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic int unsigned next_gap();
		if (send_calm || $urandom_range(0, 9) < 7)
			return 0;
		return pick_gap();
	endfunction

	function automatic int unsigned live_size();
		return (size_setting > rmst_pkg::LEAVES) ? rmst_pkg::LEAVES : size_setting;
	endfunction

	// Writes update one leaf; queries scan the clipped range, ties going to the right.
	function automatic void apply_request(seg_req_t r);
		int unsigned n;
		int unsigned hi;
		rmst_pkg::node_t best;
		n = live_size();
		best = rmst_pkg::NODE_EMPTY;
		if (r.op == rmst_pkg::OP_WRITE) begin
			if (r.position < n)
				leaf_store[r.position] = '{key: r.key, tag: r.tag};
		end else begin
			if (r.position < n) begin
				hi = (r.right_end > n - 1) ? n - 1 : r.right_end;
				for (int unsigned i = r.position; i <= hi; i++) begin
					if (leaf_store[i].key <= best.key)
						best = leaf_store[i];
				end
			end
			if (best.key == {rmst_pkg::KEY_W{1'b1}})
				best.tag = '0;
			expected_mins.push_back(best);
		end
	endfunction

	task automatic push_item(input rmst_pkg::op_t op, input int unsigned pos,
		input int unsigned rend, input int unsigned key, input int unsigned tag);
		seg_req_t r;
		r.op = op;
		r.position = rmst_pkg::POS_W'(pos);
		r.right_end = rmst_pkg::POS_W'(rend);
		r.key = rmst_pkg::KEY_W'(key);
		r.tag = rmst_pkg::TAG_W'(tag);
		r.lead_gap = next_gap();
		pending_reqs.push_back(r);
		queued_total++;
		if (op == rmst_pkg::OP_QUERY)
			queries_queued++;
	endtask

	task automatic push_write(input int unsigned pos, input int unsigned key,
		input int unsigned tag);
		push_item(rmst_pkg::OP_WRITE, pos, $urandom, key, tag);
	endtask

	task automatic push_query(input int unsigned lo, input int unsigned hi);
		push_item(rmst_pkg::OP_QUERY, lo, hi, $urandom, $urandom);
	endtask

	task automatic push_random_item();
		int unsigned n;
		int unsigned lo;
		int unsigned hi;
		int unsigned key;
		int unsigned sel;
		n = live_size();
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 45) begin
			if (sel < 40)
				key = $urandom_range(0, 15);
			else if (sel < 50)
				key = 16'hFFFF;
			else if (sel < 60)
				key = 0;
			else
				key = $urandom_range(0, 16'hFFFF);
			lo = ($urandom_range(0, 9) == 0) ? $urandom_range(0, rmst_pkg::LEAVES - 1)
				: $urandom_range(0, n - 1);
			push_write(lo, key, $urandom_range(0, 16'hFFFF));
		end else begin
			if (sel < 40) begin
				lo = $urandom_range(0, n - 1);
				hi = lo + $urandom_range(0, 20);
				if (hi > rmst_pkg::LEAVES - 1)
					hi = rmst_pkg::LEAVES - 1;
			end else if (sel < 60) begin
				lo = $urandom_range(0, rmst_pkg::LEAVES - 1);
				hi = $urandom_range(0, rmst_pkg::LEAVES - 1);
			end else if (sel < 70) begin
				hi = $urandom_range(0, rmst_pkg::LEAVES - 2);
				lo = $urandom_range(hi + 1, rmst_pkg::LEAVES - 1);
			end else if (sel < 85) begin
				lo = 0;
				hi = rmst_pkg::LEAVES - 1;
			end else begin
				lo = $urandom_range(0, n - 1);
				hi = $urandom_range(n - 1, rmst_pkg::LEAVES - 1);
			end
			push_query(lo, hi);
		end
	endtask

	task automatic wait_drained();
		while (queued_total != requests_accepted || expected_mins.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_size(input int unsigned value);
		wait_drained();
		repeat (40) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= rmst_pkg::SIZE_W'(value);
		size_setting = rmst_pkg::SIZE_W'(value);
		size_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Request driver.
	seg_req_t    cur_req;
	int unsigned gap_count;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.opcode <= '0;
			req_ch.position <= '0;
			req_ch.right_end <= '0;
			req_ch.key_value <= '0;
			req_ch.tag_value <= '0;
			gap_count = 0;
		end else begin
			if (req_ch.valid && req_ch.ready) begin
				apply_request(cur_req);
				requests_accepted++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_reqs.size() != 0 && gap_count >= pending_reqs[0].lead_gap) begin
					cur_req = pending_reqs.pop_front();
					req_ch.valid <= 1'b1;
					req_ch.opcode <= cur_req.op;
					req_ch.position <= cur_req.position;
					req_ch.right_end <= cur_req.right_end;
					req_ch.key_value <= cur_req.key;
					req_ch.tag_value <= cur_req.tag;
					gap_count = 0;
				end else begin
					req_ch.valid <= 1'b0;
					if (pending_reqs.size() != 0)
						gap_count++;
				end
			end
		end
	end

	// Result monitor with its own back-pressure.
	rmst_pkg::node_t want;
	int unsigned     hold_left;
	int unsigned     stall_left;
	int unsigned     calm_left;
	bit              recv_calm;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			hold_left = 0;
			stall_left = 0;
			calm_left = 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_mins.size() == 0) begin
					$error("unexpected result: min_key %0h min_tag %0h",
						rsp_ch.min_key, rsp_ch.min_tag);
					mismatches++;
				end else begin
					want = expected_mins.pop_front();
					if (rsp_ch.min_key !== want.key) begin
						$error("min_key mismatch: expected %0h, actual %0h",
							want.key, rsp_ch.min_key);
						mismatches++;
					end
					if (rsp_ch.min_tag !== want.tag) begin
						$error("min_tag mismatch: expected %0h, actual %0h",
							want.tag, rsp_ch.min_tag);
						mismatches++;
					end
				end
				results_seen++;
				if (results_seen == 60 || results_seen == 800)
					hold_left = 400;
			end
			if (calm_left == 0) begin
				calm_left = $urandom_range(50, 300);
				recv_calm = ($urandom_range(0, 2) == 0);
			end
			calm_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
				stall_left = pick_gap() - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		int unsigned phase_sizes [7];
		req_ch.valid = 1'b0;
		req_ch.opcode = '0;
		req_ch.position = '0;
		req_ch.right_end = '0;
		req_ch.key_value = '0;
		req_ch.tag_value = '0;
		rsp_ch.ready = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < rmst_pkg::LEAVES; i++)
			leaf_store[i] = rmst_pkg::NODE_EMPTY;
		size_setting = rmst_pkg::SIZE_W'(rmst_pkg::LEAVES);
		send_calm = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_size(1024);
		push_query(0, 1023);
		push_write(0, 0, 16'hFFFF);
		push_write(1023, 0, 16'h1234);
		push_query(0, 1023);
		push_query(0, 0);
		push_query(5, 3);
		push_write(500, 16'hFFFF, 16'hABCD);
		push_query(500, 500);
		push_write(10, 7, 16'h0001);
		push_write(20, 7, 16'h0002);
		push_query(10, 20);
		push_write(511, 16'h8000, 16'h5555);
		push_write(512, 16'h7FFF, 16'hAAAA);
		push_query(511, 512);
		push_query(1023, 0);
		push_write(1023, 16'hFFFF, 16'hFFFF);
		push_query(1000, 1023);

		write_size(0);
		push_write(0, 1, 1);
		push_query(0, 1023);

		write_size(2047);
		push_write(1023, 3, 9);
		push_query(600, 1023);

		write_size(7);
		push_write(7, 0, 16'h0077);
		push_write(6, 16'h0010, 16'h0066);
		push_query(5, 100);
		push_query(7, 9);

		phase_sizes[0] = 1024;
		phase_sizes[1] = 1;
		phase_sizes[2] = 37;
		phase_sizes[3] = 2047;
		phase_sizes[4] = $urandom_range(2, 1023);
		phase_sizes[5] = 1000;
		phase_sizes[6] = 512;
		foreach (phase_sizes[p]) begin
			write_size(phase_sizes[p]);
			for (int k = 0; k < 250; k++) begin
				if (k % 100 == 0)
					send_calm = ($urandom_range(0, 2) == 0);
				push_random_item();
			end
		end

		wait_drained();
		repeat (40) @(posedge clk);
		$display("Run covered %0d requests (%0d range queries) across %0d size settings.",
			requests_accepted, queries_queued, size_writes);
		$display("Results checked: %0d, mismatches: %0d.", results_seen, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#9_600_000;
		$display("Run timed out with %0d of %0d requests accepted.",
			requests_accepted, queued_total);
		$display("Some tests failed");
		$finish;
	end

endmodule
